// File: design/wwpi_pkg.sv
// Shared types, constants and datapath command codes for the weighted walk block.
// No dependencies; every other design file except wwpi_ram imports this package.
package wwpi_pkg;

   localparam int NODE_W    = 10;
   localparam int MAX_NODES = 1024;
   localparam int CNT_W     = 11;
   localparam int MAX_EDGES = 4096;
   localparam int EDGE_AW   = 12;
   localparam int FILL_W    = 13;
   localparam int WEIGHT_W  = 16;
   localparam int PROB_W    = 32;
   localparam int PROB_FRAC = 31;
   localparam int SUM_W     = 32;
   localparam int STEP_W    = 8;
   localparam int PROD_W    = PROB_W + WEIGHT_W;
   localparam int DIV_CNT_W = 6;
   localparam int BANK_AW   = NODE_W + 1;
   localparam int CSR_W     = 11;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_QUERY = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_ORDER = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   localparam logic CSR_STEP_LIMIT = 1'b0;
   localparam logic CSR_NODE_COUNT = 1'b1;

   localparam logic [STEP_W-1:0]    STEP_LIMIT_RESET = STEP_W'(10);
   localparam logic [CNT_W-1:0]     NODE_COUNT_RESET = CNT_W'(MAX_NODES);
   localparam logic [CNT_W-1:0]     NODE_LIMIT_MAX   = CNT_W'(MAX_NODES);
   localparam logic [FILL_W-1:0]    EDGE_LIMIT       = FILL_W'(MAX_EDGES);
   localparam logic [PROB_W-1:0]    PROB_ONE         = PROB_W'(1) << PROB_FRAC;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST         = DIV_CNT_W'(PROD_W - 1);

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_NOREAD,
      OP_QSTART,
      OP_CLEAR_ALL,
      OP_CLEAR_PROB,
      OP_SEED,
      OP_LEVEL,
      OP_NEXT_LEVEL,
      OP_RD_LIST,
      OP_RD_NODE,
      OP_NODE,
      OP_RD_EDGE,
      OP_EDGE,
      OP_DIV_STEP,
      OP_ACC,
      OP_RD_LIST_OUT,
      OP_RD_PROB_OUT,
      OP_OUT_QUERY,
      OP_OUT_READ
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic bad_start;
      logic walk_end;
      logic nodes_done;
      logic node_skip;
      logic edges_done;
      logic tgt_bad;
      logic div_last;
   } stat_type;

   typedef struct packed {
      logic [1:0]          mode;
      logic [NODE_W-1:0]   edge_source;
      logic [NODE_W-1:0]   edge_target;
      logic [WEIGHT_W-1:0] edge_weight;
      logic [NODE_W-1:0]   start_node;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] node_id;
      logic [PROB_W-1:0] probability;
      logic [CNT_W-1:0]  result_count;
      logic              last;
      logic [1:0]        status;
   } rsp_type;

endpackage

// File: design/wwpi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wwpi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/wwpi_dp.sv
// Datapath: configuration, edge and walk memories, counters, share divider, result register.
// Depends on wwpi_pkg and wwpi_ram.
module wwpi_dp import wwpi_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output stat_type         stat,
   input  req_type          req_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   output rsp_type          rsp_data
);

   logic [STEP_W-1:0]  step_limit_ff;
   logic [CNT_W-1:0]   node_count_ff;
   logic [FILL_W-1:0]  fill_ff;
   logic               any_ff;
   logic [NODE_W-1:0]  last_ff;
   logic [SUM_W-1:0]   run_sum_ff;
   logic [BANK_AW-1:0] clr_ff;
   logic [CNT_W-1:0]   size0_ff;
   logic [CNT_W-1:0]   size1_ff;
   logic [CNT_W-1:0]   rp_ff;
   logic               rl_ff;
   logic [STEP_W-1:0]  level_ff;
   logic [STEP_W-1:0]  walk_steps_ff;

   logic [NODE_W-1:0]    start_ff;
   logic                 bad_start_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [CNT_W-1:0]     j_ff;
   logic [NODE_W-1:0]    v_ff;
   logic [PROB_W-1:0]    mass_ff;
   logic [SUM_W-1:0]     wsum_ff;
   logic [FILL_W-1:0]    e_ff;
   logic [FILL_W-1:0]    hi_ff;
   logic [NODE_W-1:0]    t_ff;
   logic [PROD_W-1:0]    quo_ff;
   logic [SUM_W-1:0]     rem_ff;
   logic [DIV_CNT_W-1:0] dcnt_ff;
   rsp_type              rsp_ff;

   logic [SUM_W-1:0]    sum_q;
   logic [FILL_W-1:0]   start_q;
   logic [FILL_W-1:0]   end_q;
   logic [NODE_W-1:0]   tgt_q;
   logic [WEIGHT_W-1:0] wgt_q;
   logic [PROB_W:0]     prob_q;
   logic [NODE_W-1:0]   list_q;

   logic               cur;
   logic               nxt;
   logic [CNT_W-1:0]   size_cur;
   logic [CNT_W-1:0]   size_nxt;
   logic [CNT_W-1:0]   size_rl;
   logic [CNT_W-1:0]   node_lim;
   logic               ld_bad;
   logic               ld_full;
   logic [1:0]         ld_status;
   logic               ld_ok;
   logic               new_src;
   logic [SUM_W-1:0]   run_sum_in;
   logic [SUM_W:0]     rem_sh;
   logic               div_ge;
   logic [SUM_W-1:0]   rem_in;
   logic [PROD_W-1:0]  prod;
   logic [PROB_W-1:0]  acc_sum;
   logic               read_avail;

   logic               prob_we;
   logic [BANK_AW-1:0] prob_wa;
   logic [PROB_W:0]    prob_wd;
   logic               prob_re;
   logic [BANK_AW-1:0] prob_ra;
   logic               list_we;
   logic [BANK_AW-1:0] list_wa;
   logic [NODE_W-1:0]  list_wd;
   logic               list_re;
   logic [BANK_AW-1:0] list_ra;
   logic               sum_we;
   logic [NODE_W-1:0]  sum_wa;
   logic [SUM_W-1:0]   sum_wd;
   logic               node_re;
   logic               edge_re;

   assign cur      = level_ff[0];
   assign nxt      = ~level_ff[0];
   assign size_cur = cur ? size1_ff : size0_ff;
   assign size_nxt = nxt ? size1_ff : size0_ff;
   assign size_rl  = rl_ff ? size1_ff : size0_ff;

   always_comb begin
      if (node_count_ff == '0) begin
         node_lim = CNT_W'(1);
      end else if (node_count_ff > NODE_LIMIT_MAX) begin
         node_lim = NODE_LIMIT_MAX;
      end else begin
         node_lim = node_count_ff;
      end
   end

   // edge load checks: malformed or out of order first, then table full
   assign ld_bad = ({1'b0, req_data.edge_source} >= node_lim)
                || ({1'b0, req_data.edge_target} >= node_lim)
                || (req_data.edge_weight == '0)
                || (any_ff && (req_data.edge_source < last_ff));
   assign ld_full = fill_ff >= EDGE_LIMIT;
   assign ld_status = ld_bad ? ST_ORDER : (ld_full ? ST_FULL : ST_OK);
   assign ld_ok = (cmd.op == OP_LOAD) && !ld_bad && !ld_full;
   assign new_src = !any_ff || (req_data.edge_source != last_ff);
   assign run_sum_in = new_src ? SUM_W'(req_data.edge_weight)
                               : run_sum_ff + SUM_W'(req_data.edge_weight);

   // one restoring division step per cycle
   assign rem_sh = {rem_ff, quo_ff[PROD_W-1]};
   assign div_ge = rem_sh >= {1'b0, wsum_ff};
   assign rem_in = div_ge ? SUM_W'(rem_sh - {1'b0, wsum_ff}) : rem_sh[SUM_W-1:0];

   assign prod = mass_ff * wgt_q;
   assign acc_sum = prob_q[PROB_W-1:0] + quo_ff[PROB_W-1:0];
   assign read_avail = rp_ff < size_rl;

   assign stat.clear_last = &clr_ff;
   assign stat.bad_start  = bad_start_ff;
   assign stat.walk_end   = (level_ff == walk_steps_ff) || (size_cur == '0);
   assign stat.nodes_done = j_ff == cnt_ff;
   assign stat.node_skip  = !any_ff || (v_ff > last_ff) || (sum_q == '0);
   assign stat.edges_done = e_ff == hi_ff;
   assign stat.tgt_bad    = {1'b0, tgt_q} >= node_lim;
   assign stat.div_last   = dcnt_ff == DIV_LAST;

   always_comb begin
      prob_we = 1'b0;
      prob_wa = '0;
      prob_wd = '0;
      prob_re = 1'b0;
      prob_ra = '0;
      list_we = 1'b0;
      list_wa = '0;
      list_wd = '0;
      list_re = 1'b0;
      list_ra = '0;
      case (cmd.op)
         OP_CLEAR_ALL, OP_CLEAR_PROB: begin
            prob_we = 1'b1;
            prob_wa = clr_ff;
         end
         OP_SEED: begin
            prob_we = 1'b1;
            prob_wa = {1'b0, start_ff};
            prob_wd = {1'b1, PROB_ONE};
            list_we = 1'b1;
            list_wd = start_ff;
         end
         OP_RD_LIST: begin
            list_re = 1'b1;
            list_ra = {cur, j_ff[NODE_W-1:0]};
         end
         OP_RD_NODE: begin
            prob_re = 1'b1;
            prob_ra = {cur, list_q};
         end
         OP_NODE: begin
            prob_we = 1'b1;
            prob_wa = {cur, v_ff};
         end
         OP_EDGE: begin
            prob_re = 1'b1;
            prob_ra = {nxt, tgt_q};
         end
         OP_ACC: begin
            prob_we = 1'b1;
            prob_wa = {nxt, t_ff};
            prob_wd = {1'b1, acc_sum};
            list_we = !prob_q[PROB_W];
            list_wa = {nxt, size_nxt[NODE_W-1:0]};
            list_wd = t_ff;
         end
         OP_RD_LIST_OUT: begin
            list_re = 1'b1;
            list_ra = {rl_ff, rp_ff[NODE_W-1:0]};
         end
         OP_RD_PROB_OUT: begin
            prob_re = 1'b1;
            prob_ra = {rl_ff, list_q};
         end
         default: begin
         end
      endcase
   end

   assign sum_we  = ld_ok || ((cmd.op == OP_CLEAR_ALL) && !clr_ff[BANK_AW-1]);
   assign sum_wa  = ld_ok ? req_data.edge_source : clr_ff[NODE_W-1:0];
   assign sum_wd  = ld_ok ? run_sum_in : '0;
   assign node_re = cmd.op == OP_RD_NODE;
   assign edge_re = cmd.op == OP_RD_EDGE;

   wwpi_ram #(.WIDTH(SUM_W), .DEPTH(MAX_NODES)) u_sum_ram (
      .clock(clock), .wr_en(sum_we), .wr_addr(sum_wa), .wr_data(sum_wd),
      .rd_en(node_re), .rd_addr(list_q), .rd_data(sum_q)
   );

   wwpi_ram #(.WIDTH(FILL_W), .DEPTH(MAX_NODES)) u_start_ram (
      .clock(clock), .wr_en(ld_ok && new_src), .wr_addr(req_data.edge_source),
      .wr_data(fill_ff), .rd_en(node_re), .rd_addr(list_q), .rd_data(start_q)
   );

   wwpi_ram #(.WIDTH(FILL_W), .DEPTH(MAX_NODES)) u_end_ram (
      .clock(clock), .wr_en(ld_ok), .wr_addr(req_data.edge_source),
      .wr_data(fill_ff + FILL_W'(1)), .rd_en(node_re), .rd_addr(list_q), .rd_data(end_q)
   );

   wwpi_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_tgt_ram (
      .clock(clock), .wr_en(ld_ok), .wr_addr(fill_ff[EDGE_AW-1:0]),
      .wr_data(req_data.edge_target), .rd_en(edge_re), .rd_addr(e_ff[EDGE_AW-1:0]),
      .rd_data(tgt_q)
   );

   wwpi_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_EDGES)) u_wgt_ram (
      .clock(clock), .wr_en(ld_ok), .wr_addr(fill_ff[EDGE_AW-1:0]),
      .wr_data(req_data.edge_weight), .rd_en(edge_re), .rd_addr(e_ff[EDGE_AW-1:0]),
      .rd_data(wgt_q)
   );

   // probability with frontier flag on top, two banks addressed {bank, node}
   wwpi_ram #(.WIDTH(PROB_W + 1), .DEPTH(2 * MAX_NODES)) u_prob_ram (
      .clock(clock), .wr_en(prob_we), .wr_addr(prob_wa), .wr_data(prob_wd),
      .rd_en(prob_re), .rd_addr(prob_ra), .rd_data(prob_q)
   );

   wwpi_ram #(.WIDTH(NODE_W), .DEPTH(2 * MAX_NODES)) u_list_ram (
      .clock(clock), .wr_en(list_we), .wr_addr(list_wa), .wr_data(list_wd),
      .rd_en(list_re), .rd_addr(list_ra), .rd_data(list_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         step_limit_ff <= STEP_LIMIT_RESET;
         node_count_ff <= NODE_COUNT_RESET;
         fill_ff       <= '0;
         any_ff        <= 1'b0;
         last_ff       <= '0;
         run_sum_ff    <= '0;
         clr_ff        <= '0;
         size0_ff      <= '0;
         size1_ff      <= '0;
         rp_ff         <= '0;
         rl_ff         <= 1'b0;
         level_ff      <= '0;
         walk_steps_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_STEP_LIMIT: step_limit_ff <= csr_wdata[STEP_W-1:0];
               CSR_NODE_COUNT: node_count_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         case (cmd.op)
            OP_LOAD: begin
               if (ld_ok) begin
                  fill_ff    <= fill_ff + FILL_W'(1);
                  any_ff     <= 1'b1;
                  last_ff    <= req_data.edge_source;
                  run_sum_ff <= run_sum_in;
               end
            end
            OP_QSTART: begin
               clr_ff        <= '0;
               size0_ff      <= '0;
               size1_ff      <= '0;
               rp_ff         <= '0;
               rl_ff         <= step_limit_ff[0];
               level_ff      <= '0;
               walk_steps_ff <= step_limit_ff;
            end
            OP_CLEAR_ALL, OP_CLEAR_PROB: clr_ff <= clr_ff + BANK_AW'(1);
            OP_SEED: size0_ff <= CNT_W'(1);
            OP_LEVEL: begin
               if (cur) begin
                  size1_ff <= '0;
               end else begin
                  size0_ff <= '0;
               end
            end
            OP_NEXT_LEVEL: level_ff <= level_ff + STEP_W'(1);
            OP_ACC: begin
               if (!prob_q[PROB_W]) begin
                  if (nxt) begin
                     size1_ff <= size1_ff + CNT_W'(1);
                  end else begin
                     size0_ff <= size0_ff + CNT_W'(1);
                  end
               end
            end
            OP_OUT_READ: begin
               if (read_avail) begin
                  rp_ff <= rp_ff + CNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: rsp_ff <= '{node_id: '0, probability: '0, result_count: '0,
                              last: 1'b0, status: ld_status};
         OP_NOREAD: rsp_ff <= '{node_id: '0, probability: '0, result_count: '0,
                                last: 1'b0, status: ST_EMPTY};
         OP_QSTART: begin
            start_ff     <= req_data.start_node;
            bad_start_ff <= {1'b0, req_data.start_node} >= node_lim;
         end
         OP_LEVEL: begin
            cnt_ff <= size_cur;
            j_ff   <= '0;
         end
         OP_RD_NODE: v_ff <= list_q;
         OP_NODE: begin
            mass_ff <= prob_q[PROB_W-1:0];
            wsum_ff <= sum_q;
            e_ff    <= start_q;
            hi_ff   <= end_q;
            j_ff    <= j_ff + CNT_W'(1);
         end
         OP_EDGE: begin
            t_ff    <= tgt_q;
            quo_ff  <= prod;
            rem_ff  <= '0;
            dcnt_ff <= '0;
            e_ff    <= e_ff + FILL_W'(1);
         end
         OP_DIV_STEP: begin
            quo_ff  <= {quo_ff[PROD_W-2:0], div_ge};
            rem_ff  <= rem_in;
            dcnt_ff <= dcnt_ff + DIV_CNT_W'(1);
         end
         OP_RD_PROB_OUT: v_ff <= list_q;
         OP_OUT_QUERY: rsp_ff <= '{node_id: '0, probability: '0, result_count: size_rl,
                                   last: 1'b0, status: ST_OK};
         OP_OUT_READ: begin
            if (read_avail) begin
               rsp_ff <= '{node_id: v_ff, probability: prob_q[PROB_W-1:0],
                           result_count: size_rl,
                           last: (rp_ff + CNT_W'(1)) == size_rl, status: ST_OK};
            end else begin
               rsp_ff <= '{node_id: '0, probability: '0, result_count: size_rl,
                           last: 1'b0, status: ST_EMPTY};
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_data = rsp_ff;

endmodule

// File: design/wwpi_ctrl.sv
// Controller: sequences loads, memory clears, the level/node/edge walk and readout.
// Depends on wwpi_pkg; drives the datapath through cmd_type and reads stat_type.
module wwpi_ctrl import wwpi_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_mode,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  stat_type   stat,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_CLR_RST,
      S_IDLE,
      S_CLR_Q,
      S_SEED,
      S_LEVEL,
      S_NODE_CHK,
      S_NODE_RD,
      S_NODE_CAP,
      S_EDGE_CHK,
      S_EDGE_CAP,
      S_DIV,
      S_ACC,
      S_OUT_RD,
      S_RESP_Q,
      S_RESP_R
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;
   op_type    op;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);

   always_comb begin
      op       = OP_NONE;
      state_in = state_ff;
      case (state_ff)
         S_CLR_RST: begin
            op = OP_CLEAR_ALL;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid && out_free) begin
               case (req_mode)
                  MODE_LOAD: op = OP_LOAD;
                  MODE_QUERY: begin
                     op       = OP_QSTART;
                     state_in = S_CLR_Q;
                  end
                  MODE_READ: begin
                     op       = OP_RD_LIST_OUT;
                     state_in = S_OUT_RD;
                  end
                  default: op = OP_NOREAD;
               endcase
            end
         end
         S_CLR_Q: begin
            op = OP_CLEAR_PROB;
            if (stat.clear_last) begin
               state_in = S_SEED;
            end
         end
         S_SEED: begin
            if (stat.bad_start) begin
               state_in = S_RESP_Q;
            end else begin
               op       = OP_SEED;
               state_in = S_LEVEL;
            end
         end
         S_LEVEL: begin
            if (stat.walk_end) begin
               state_in = S_RESP_Q;
            end else begin
               op       = OP_LEVEL;
               state_in = S_NODE_CHK;
            end
         end
         S_NODE_CHK: begin
            if (stat.nodes_done) begin
               op       = OP_NEXT_LEVEL;
               state_in = S_LEVEL;
            end else begin
               op       = OP_RD_LIST;
               state_in = S_NODE_RD;
            end
         end
         S_NODE_RD: begin
            op       = OP_RD_NODE;
            state_in = S_NODE_CAP;
         end
         S_NODE_CAP: begin
            op       = OP_NODE;
            state_in = stat.node_skip ? S_NODE_CHK : S_EDGE_CHK;
         end
         S_EDGE_CHK: begin
            if (stat.edges_done) begin
               state_in = S_NODE_CHK;
            end else begin
               op       = OP_RD_EDGE;
               state_in = S_EDGE_CAP;
            end
         end
         S_EDGE_CAP: begin
            op       = OP_EDGE;
            state_in = stat.tgt_bad ? S_EDGE_CHK : S_DIV;
         end
         S_DIV: begin
            op = OP_DIV_STEP;
            if (stat.div_last) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            op       = OP_ACC;
            state_in = S_EDGE_CHK;
         end
         S_OUT_RD: begin
            op       = OP_RD_PROB_OUT;
            state_in = S_RESP_R;
         end
         S_RESP_Q: begin
            if (out_free) begin
               op       = OP_OUT_QUERY;
               state_in = S_IDLE;
            end
         end
         S_RESP_R: begin
            if (out_free) begin
               op       = OP_OUT_READ;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // set on a result load, drop once the consumer takes the transfer
   always_comb begin
      if ((op == OP_LOAD) || (op == OP_NOREAD) || (op == OP_OUT_QUERY)
          || (op == OP_OUT_READ)) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign cmd.op    = op;
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/weighted_walk_power_iteration.sv
// Top level of the weighted random-walk power iteration block.
// Depends on wwpi_pkg, wwpi_ctrl, wwpi_dp (and wwpi_ram through the datapath).
//
//   port group   direction  contents
//   req_*        in         valid/stall, req_type: mode, edge, start node
//   rsp_*        out        valid/stall, rsp_type: node, probability, count, last, status
//   csr_*        in         write enable, index (0 step_limit, 1 node_count), data
//
// An edge load and an unused mode are answered from the idle state, so loads stream
// one per cycle while the result side does not stall. A query clears both probability
// banks, then handles each frontier node (list read, node read, node capture) and each
// of its edges (edge read, edge capture, 48-step bit-serial share divider, accumulate).
// A readout does a list read, then a probability read. After reset the block clears
// its probability and weight-sum memories and holds req_stall high meanwhile.
// A result waiting under rsp_stall holds req_stall high while the block is idle.
module weighted_walk_power_iteration import wwpi_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   wwpi_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_mode(req_data.mode),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .stat(stat),
      .cmd(cmd)
   );

   wwpi_dp u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .stat(stat),
      .req_data(req_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_data(rsp_data)
   );

endmodule

// File: tb/wwpi_checker.sv
// Checker for the weighted walk block: watches the request, result and register ports,
// predicts each result and compares it field by field. Depends on wwpi_pkg.
`timescale 1ns / 1ps
module wwpi_checker import wwpi_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   output int               fail_count,
   output int               pending,
   output int               checked,
   output int               walk_count,
   output int               edge_total
);

   bit [STEP_W-1:0]   step_limit = STEP_LIMIT_RESET;
   bit [CNT_W-1:0]    node_count = NODE_COUNT_RESET;
   int                src_base [0:MAX_NODES];
   bit [NODE_W-1:0]   tgt_mem [MAX_EDGES];
   longint unsigned   wgt_mem [MAX_EDGES];
   longint unsigned   out_sum [MAX_NODES];
   longint unsigned   mass_tab [2][MAX_NODES];
   bit                member [2][MAX_NODES];
   int                front [2][MAX_NODES];
   int                front_len [2];
   int                fill, read_ptr, top_src, out_bank;
   bit                any_edge;
   rsp_type           result_q[$];

   initial begin
      fail_count = 0;
      pending = 0;
      checked = 0;
      walk_count = 0;
      edge_total = 0;
      fill = 0;
      read_ptr = 0;
      top_src = 0;
      out_bank = 0;
      any_edge = 0;
      front_len[0] = 0;
      front_len[1] = 0;
      foreach (out_sum[i]) out_sum[i] = 0;
      foreach (mass_tab[b, i]) begin
         mass_tab[b][i] = 0;
         member[b][i] = 0;
      end
   end

   function automatic int node_limit();
      if (node_count == 0) return 1;
      if (node_count > MAX_NODES) return MAX_NODES;
      return int'(node_count);
   endfunction

   task automatic walk_result(input req_type r, output rsp_type o);
      int lim, cur, nxt, cnt, v, hi, t, src, start;
      longint unsigned mass;
      o = '0;
      lim = node_limit();
      src = int'(r.edge_source);
      start = int'(r.start_node);
      case (r.mode)
         MODE_LOAD: begin
            if (src >= lim || int'(r.edge_target) >= lim || r.edge_weight == 0)
               o.status = ST_ORDER;
            else if (any_edge && src < top_src)
               o.status = ST_ORDER;
            else if (fill >= MAX_EDGES)
               o.status = ST_FULL;
            else begin
               if (!any_edge || src > top_src) begin
                  for (int k = any_edge ? top_src + 1 : 0; k <= src; k++)
                     src_base[k] = fill;
                  top_src = src;
                  any_edge = 1;
               end
               tgt_mem[fill] = r.edge_target;
               wgt_mem[fill] = 64'(r.edge_weight);
               fill++;
               out_sum[src] += 64'(r.edge_weight);
               o.status = ST_OK;
            end
         end
         MODE_QUERY: begin
            foreach (mass_tab[b, i]) begin
               mass_tab[b][i] = 0;
               member[b][i] = 0;
            end
            front_len[0] = 0;
            front_len[1] = 0;
            read_ptr = 0;
            out_bank = int'(step_limit[0]);
            if (start < lim) begin
               front[0][0] = start;
               front_len[0] = 1;
               member[0][start] = 1;
               mass_tab[0][start] = 64'(PROB_ONE);
               for (int lvl = 0; lvl < int'(step_limit); lvl++) begin
                  cur = lvl & 1;
                  nxt = cur ^ 1;
                  cnt = front_len[cur];
                  if (cnt == 0) break;
                  front_len[cur] = 0;
                  for (int j = 0; j < cnt; j++) begin
                     v = front[cur][j];
                     mass = mass_tab[cur][v];
                     mass_tab[cur][v] = 0;
                     member[cur][v] = 0;
                     if (!any_edge || v > top_src || out_sum[v] == 0) continue;
                     hi = (v < top_src) ? src_base[v + 1] : fill;
                     for (int e = src_base[v]; e < hi && e < MAX_EDGES; e++) begin
                        t = int'(tgt_mem[e]);
                        if (t >= lim) continue;
                        mass_tab[nxt][t] += (mass * wgt_mem[e]) / out_sum[v];
                        if (!member[nxt][t]) begin
                           member[nxt][t] = 1;
                           front[nxt][front_len[nxt]] = t;
                           front_len[nxt]++;
                        end
                     end
                  end
               end
            end
            o.result_count = CNT_W'(front_len[out_bank]);
            walk_count = front_len[out_bank];
         end
         MODE_READ: begin
            o.result_count = CNT_W'(front_len[out_bank]);
            if (read_ptr < front_len[out_bank]) begin
               v = front[out_bank][read_ptr];
               o.node_id = NODE_W'(v);
               o.probability = PROB_W'(mass_tab[out_bank][v]);
               mass_tab[out_bank][v] = 0;
               member[out_bank][v] = 0;
               read_ptr++;
               o.last = (read_ptr == front_len[out_bank]);
            end else
               o.status = ST_EMPTY;
         end
         default: o.status = ST_EMPTY;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type exp_rsp, got;
      if (!reset) begin
         if (csr_we) begin
            if (csr_index == CSR_STEP_LIMIT) step_limit = csr_wdata[STEP_W-1:0];
            else node_count = csr_wdata;
         end
         // compare first: a result never belongs to a request accepted on the same edge
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (result_q.size() == 0) begin
               $error("result transfer with no expectation waiting");
               fail_count++;
            end else begin
               exp_rsp = result_q.pop_front();
               checked++;
               if (got.node_id !== exp_rsp.node_id) begin
                  $error("node_id expected %0d actual %0d", exp_rsp.node_id, got.node_id);
                  fail_count++;
               end
               if (got.probability !== exp_rsp.probability) begin
                  $error("probability expected %0h actual %0h",
                         exp_rsp.probability, got.probability);
                  fail_count++;
               end
               if (got.result_count !== exp_rsp.result_count) begin
                  $error("result_count expected %0d actual %0d",
                         exp_rsp.result_count, got.result_count);
                  fail_count++;
               end
               if (got.last !== exp_rsp.last) begin
                  $error("last expected %0d actual %0d", exp_rsp.last, got.last);
                  fail_count++;
               end
               if (got.status !== exp_rsp.status) begin
                  $error("status expected %0d actual %0d", exp_rsp.status, got.status);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            walk_result(req_data, exp_rsp);
            result_q.push_back(exp_rsp);
         end
         edge_total = fill;
         pending = result_q.size();
      end
   end

endmodule

// File: tb/tb.sv
// Testbench top for weighted_walk_power_iteration: clock, reset, stimulus and verdict.
// Depends on wwpi_pkg, the block under test and wwpi_checker.
`timescale 1ns / 1ps
module tb;
   import wwpi_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_data;
   logic             csr_we;
   logic             csr_index;
   logic [CSR_W-1:0] csr_wdata;
   int               fail_count, pending, checked, walk_count, edge_total;
   int               send_gap_pct, recv_gap_pct, sent, src_head;
   bit               hold_rsp;

   weighted_walk_power_iteration u_top (.*);

   wwpi_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #80_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // receiver side: random stall, plus one long hold-off on request
   initial begin
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1;
            repeat (400) @(negedge clock);
            hold_rsp = 0;
         end
         rsp_stall <= ($urandom_range(99) < recv_gap_pct);
      end
   end

   function automatic req_type rand_req();
      req_type r;
      r.mode        = 2'($urandom);
      r.edge_source = NODE_W'($urandom);
      r.edge_target = NODE_W'($urandom);
      r.edge_weight = WEIGHT_W'($urandom);
      r.start_node  = NODE_W'($urandom);
      return r;
   endfunction

   task automatic send_item(input req_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input int value);
      drain();
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= CSR_W'(value);
      @(negedge clock);
      csr_we <= 0;
   endtask

   task automatic load_edge(input int src, input int dst, input int w);
      req_type r;
      r = '0;
      r.mode = MODE_LOAD;
      r.edge_source = NODE_W'(src);
      r.edge_target = NODE_W'(dst);
      r.edge_weight = WEIGHT_W'(w);
      r.start_node = NODE_W'($urandom);
      send_item(r);
   endtask

   // start a walk, then read out up to 40 frontier entries plus extra further reads
   task automatic run_walk(input int start, input int extra);
      req_type r;
      int n;
      r = rand_req();
      r.mode = MODE_QUERY;
      r.start_node = NODE_W'(start);
      send_item(r);
      drain();
      n = (walk_count > 40) ? 40 : walk_count;
      for (int i = 0; i < n + extra; i++) begin
         r = rand_req();
         r.mode = MODE_READ;
         send_item(r);
      end
   endtask

   initial begin
      req_type r;
      int k, src, lo, hi;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_we = 0;
      csr_index = CSR_STEP_LIMIT;
      csr_wdata = '0;
      send_gap_pct = 0;
      recv_gap_pct = 0;
      sent = 0;
      hold_rsp = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: reads before any walk, unused mode, small cyclic graph
      r = '0;
      r.mode = MODE_READ;
      send_item(r);
      r.mode = MODE_UNUSED;
      send_item(r);
      load_edge(0, 1, 1);
      load_edge(0, 2, 65535);
      load_edge(1, 0, 3);
      load_edge(1, 1, 5);
      load_edge(2, 0, 7);
      load_edge(1, 2, 9);     // source below the last one
      load_edge(3, 4, 0);     // zero weight
      run_walk(0, 1);
      run_walk(1023, 1);      // no edges there: mass dropped
      write_csr(CSR_STEP_LIMIT, 255);
      write_csr(CSR_NODE_COUNT, 2);
      load_edge(3, 1023, 4);  // beyond the node limit
      run_walk(0, 1);         // target 2 now out of range
      run_walk(2, 1);         // bad start node
      write_csr(CSR_STEP_LIMIT, 0);
      write_csr(CSR_NODE_COUNT, 1);
      run_walk(0, 2);
      write_csr(CSR_STEP_LIMIT, 3);
      write_csr(CSR_NODE_COUNT, 1024);
      run_walk(0, 0);
      r = '0;
      r.mode = MODE_QUERY;    // new walk drops the unread entries
      send_item(r);
      src_head = 3;

      // random: append edge groups, then walk, mostly from a loaded region, and read out
      for (int ph = 0; ph < 130; ph++) begin
         if (ph < 43) begin
            send_gap_pct = 27;
            recv_gap_pct = 66;
         end else if (ph < 87) begin
            send_gap_pct = 66;
            recv_gap_pct = 27;
         end else begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
         end
         if ($urandom_range(3) == 0)
            write_csr(CSR_STEP_LIMIT, $urandom_range(4));
         if ($urandom_range(4) == 0)
            write_csr(CSR_NODE_COUNT, ($urandom_range(2) == 0) ? $urandom_range(1, 1024)
                                                              : 1024);
         k = $urandom_range(2, 10);
         for (int i = 0; i < k; i++) begin
            if (src_head < 900) src_head += $urandom_range(0, 2);
            src = src_head;
            lo = (src > 6) ? src - 6 : 0;
            hi = src + 6;
            case ($urandom_range(19))
               0: load_edge($urandom_range(src), $urandom_range(1022), $urandom_range(1, 65535));
               1: load_edge(src, $urandom_range(lo, hi), 0);
               2: begin
                  r = rand_req();
                  r.mode = MODE_UNUSED;
                  send_item(r);
               end
               3: load_edge(src, $urandom_range(1022), $urandom_range(1, 65535));
               default: load_edge(src, $urandom_range(lo, hi),
                                  ($urandom_range(1) == 0) ? $urandom_range(1, 15)
                                                           : $urandom_range(1, 65535));
            endcase
         end
         run_walk(($urandom_range(9) == 0) ? $urandom_range(1022)
                                           : $urandom_range(src_head > 20 ? src_head - 20 : 0,
                                                            src_head), $urandom_range(2));
      end

      // keep offering loads at the top source while the result side holds off
      write_csr(CSR_NODE_COUNT, 1024);
      write_csr(CSR_STEP_LIMIT, 2);
      hold_rsp = 1;
      for (int i = 0; i < 60; i++)
         load_edge(1023, $urandom_range(1023), $urandom_range(1, 65535));
      run_walk(0, 1);

      drain();
      repeat (200) @(negedge clock);
      $display("Covered %0d requests (good and rejected edge loads, walks, readouts), %0d edges",
               sent, edge_total);
      $display("stored, and %0d checked results under both stall patterns and a long hold-off.",
               checked);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
